// ===== hw/rtl/slm_pkg.sv =====
`default_nettype none

package slm_pkg;

  localparam int DATA_W         = 32;
  localparam int CMD_W          = 2;
  localparam int LIST_DEPTH_DEF = 32;

  // Input item command codes.
  typedef enum logic [CMD_W-1:0] {
    CMD_PUSH_A = 2'd0,
    CMD_PUSH_B = 2'd1,
    CMD_MERGE  = 2'd2
  } slm_cmd_code_t;

  typedef enum logic {
    ST_IDLE  = 1'b0,
    ST_MERGE = 1'b1
  } slm_state_t;

  // Commands from the controller to the datapath.
  typedef struct packed {
    logic push_a;
    logic push_b;
    logic step;
  } slm_cmd_t;

  // Status from the datapath to the controller.
  typedef struct packed {
    logic empty;
    logic out_free;
    logic last;
  } slm_status_t;

endpackage

`default_nettype wire

// ===== hw/rtl/slm_ram.sv =====
`default_nettype none

module slm_ram #(
  parameter int  WIDTH = 32,
  parameter int  DEPTH = 32,
  localparam int AW    = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
  input  wire logic             clk,
  input  wire logic             we,
  input  wire logic [AW-1:0]    waddr,
  input  wire logic [WIDTH-1:0] wdata,
  input  wire logic [AW-1:0]    raddr,
  output logic      [WIDTH-1:0] rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

`default_nettype wire

// ===== hw/rtl/slm_ctrl.sv =====
`default_nettype none

module slm_ctrl
  import slm_pkg::*;
(
  input  wire logic              clk,
  input  wire logic              rst_n,
  input  wire logic              in_valid,
  input  wire logic [CMD_W-1:0]  in_command,
  output logic                   in_ready,
  input  wire slm_status_t       status,
  output slm_cmd_t               cmd
);

  slm_state_t state_r;
  slm_state_t state_nxt;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= ST_IDLE;
    end else begin
      state_r <= state_nxt;
    end
  end

  always_comb begin
    state_nxt = state_r;
    case (state_r)
      ST_IDLE: begin
        if (in_valid && (in_command == CMD_MERGE) && !status.empty) begin
          state_nxt = ST_MERGE;
        end
      end
      ST_MERGE: begin
        if (status.out_free && status.last) begin
          state_nxt = ST_IDLE;
        end
      end
      default: state_nxt = ST_IDLE;
    endcase
  end

  always_comb begin
    in_ready   = 1'b0;
    cmd.push_a = 1'b0;
    cmd.push_b = 1'b0;
    cmd.step   = 1'b0;
    case (state_r)
      ST_IDLE: begin
        in_ready   = 1'b1;
        cmd.push_a = in_valid && (in_command == CMD_PUSH_A);
        cmd.push_b = in_valid && (in_command == CMD_PUSH_B);
      end
      ST_MERGE: begin
        cmd.step = status.out_free;
      end
      default: begin
        in_ready = 1'b0;
      end
    endcase
  end

endmodule

`default_nettype wire

// ===== hw/rtl/slm_dp.sv =====
`default_nettype none

module slm_dp
  import slm_pkg::*;
#(
  parameter int LIST_DEPTH = LIST_DEPTH_DEF
) (
  input  wire logic                     clk,
  input  wire logic                     rst_n,
  input  wire slm_cmd_t                 cmd,
  input  wire logic signed [DATA_W-1:0] in_value,
  output slm_status_t                   status,
  output logic                          out_valid,
  input  wire logic                     out_ready,
  output logic signed [DATA_W-1:0]      out_merged_value,
  output logic                          out_from_list_b,
  output logic                          out_last,
  output logic                          out_overflowed
);

  localparam int AW = (LIST_DEPTH > 1) ? $clog2(LIST_DEPTH) : 1;
  localparam int CW = $clog2(LIST_DEPTH + 1);

  logic [CW-1:0] count_a_r, count_a_nxt;
  logic [CW-1:0] count_b_r, count_b_nxt;
  logic [CW-1:0] idx_a_r, idx_a_nxt;
  logic [CW-1:0] idx_b_r, idx_b_nxt;
  logic          overflow_r, overflow_nxt;

  logic                     out_valid_r, out_valid_nxt;
  logic signed [DATA_W-1:0] out_value_r;
  logic                     out_from_b_r;
  logic                     out_last_r;
  logic                     out_ovf_r;

  logic [DATA_W-1:0] head_a;
  logic [DATA_W-1:0] head_b;
  logic              avail_a;
  logic              avail_b;
  logic              take_a;
  logic              full_a;
  logic              full_b;
  logic [CW:0]       taken_sum;
  logic [CW:0]       total_sum;

  // The read address follows the next head index, so the registered read
  // data shows the current heads of both lists, except just after a push into an empty list.
  slm_ram #(
    .WIDTH (DATA_W),
    .DEPTH (LIST_DEPTH)
  ) u_ram_a (
    .clk   (clk),
    .we    (cmd.push_a && !full_a),
    .waddr (count_a_r[AW-1:0]),
    .wdata (in_value),
    .raddr (idx_a_nxt[AW-1:0]),
    .rdata (head_a)
  );

  slm_ram #(
    .WIDTH (DATA_W),
    .DEPTH (LIST_DEPTH)
  ) u_ram_b (
    .clk   (clk),
    .we    (cmd.push_b && !full_b),
    .waddr (count_b_r[AW-1:0]),
    .wdata (in_value),
    .raddr (idx_b_nxt[AW-1:0]),
    .rdata (head_b)
  );

  always_comb begin
    full_a    = (count_a_r == CW'(LIST_DEPTH));
    full_b    = (count_b_r == CW'(LIST_DEPTH));
    avail_a   = (idx_a_r < count_a_r);
    avail_b   = (idx_b_r < count_b_r);
    take_a    = avail_a && (!avail_b || ($signed(head_a) <= $signed(head_b)));
    taken_sum = {1'b0, idx_a_r} + {1'b0, idx_b_r} + (CW + 1)'(1);
    total_sum = {1'b0, count_a_r} + {1'b0, count_b_r};

    status.empty    = (count_a_r == '0) && (count_b_r == '0);
    status.out_free = !out_valid_r || out_ready;
    status.last     = (taken_sum == total_sum);
  end

  always_comb begin
    count_a_nxt  = count_a_r;
    count_b_nxt  = count_b_r;
    idx_a_nxt    = idx_a_r;
    idx_b_nxt    = idx_b_r;
    overflow_nxt = overflow_r;

    if (cmd.push_a) begin
      if (full_a) begin
        overflow_nxt = 1'b1;
      end else begin
        count_a_nxt = count_a_r + CW'(1);
      end
    end
    if (cmd.push_b) begin
      if (full_b) begin
        overflow_nxt = 1'b1;
      end else begin
        count_b_nxt = count_b_r + CW'(1);
      end
    end

    if (cmd.step) begin
      if (status.last) begin
        // Merge done: both lists are empty again.
        count_a_nxt = '0;
        count_b_nxt = '0;
        idx_a_nxt   = '0;
        idx_b_nxt   = '0;
      end else if (take_a) begin
        idx_a_nxt = idx_a_r + CW'(1);
      end else begin
        idx_b_nxt = idx_b_r + CW'(1);
      end
    end

    if (cmd.step) begin
      out_valid_nxt = 1'b1;
    end else if (out_ready) begin
      out_valid_nxt = 1'b0;
    end else begin
      out_valid_nxt = out_valid_r;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      count_a_r   <= '0;
      count_b_r   <= '0;
      idx_a_r     <= '0;
      idx_b_r     <= '0;
      overflow_r  <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      count_a_r   <= count_a_nxt;
      count_b_r   <= count_b_nxt;
      idx_a_r     <= idx_a_nxt;
      idx_b_r     <= idx_b_nxt;
      overflow_r  <= overflow_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.step) begin
      out_value_r  <= take_a ? head_a : head_b;
      out_from_b_r <= !take_a;
      out_last_r   <= status.last;
      out_ovf_r    <= overflow_r;
    end
  end

  assign out_valid        = out_valid_r;
  assign out_merged_value = out_value_r;
  assign out_from_list_b  = out_from_b_r;
  assign out_last         = out_last_r;
  assign out_overflowed   = out_ovf_r;

endmodule

`default_nettype wire

// ===== hw/rtl/sorted_list_merge_unit.sv =====
// Two-way stable merge of two sorted lists of signed 32-bit values.
//
// Input channel (in_valid/in_ready): each item carries a command and a value.
// Command push A or push B stores the value at the tail of that list; a push
// into a full list is dropped and sets a sticky overflow flag. Command merge
// emits every stored value in ascending signed order, list A first on ties.
// Pushes are taken one per cycle while no merge runs. A merge of N values
// keeps in_ready low until the step that gives its last result; while the
// receiver does not stall, one result is produced per cycle, bounded by the
// single compare of the two heads, since the list memories show both heads
// by the first merge step. A merge of two empty lists gives none.
//
// Result channel (out_valid/out_ready): one item per merged value, with its
// source list, a last mark on the final one and the overflow flag. Results sit
// in an output register; when the receiver stalls the merge simply pauses.
// Pushes are accepted while the last result of a merge still waits.
//
// Reset clears both list counts and the overflow flag; list contents are not
// cleared, since only entries below a count are ever used.
`default_nettype none

module sorted_list_merge_unit
  import slm_pkg::*;
#(
  parameter int LIST_DEPTH = LIST_DEPTH_DEF
) (
  input  wire logic                     clk,
  input  wire logic                     rst_n,
  input  wire logic                     in_valid,
  output logic                          in_ready,
  input  wire logic [CMD_W-1:0]         in_command,
  input  wire logic signed [DATA_W-1:0] in_value,
  output logic                          out_valid,
  input  wire logic                     out_ready,
  output logic signed [DATA_W-1:0]      out_merged_value,
  output logic                          out_from_list_b,
  output logic                          out_last,
  output logic                          out_overflowed
);

  slm_cmd_t    dp_cmd;
  slm_status_t dp_status;

  // The controller decodes accepted items and paces the merge.
  slm_ctrl u_ctrl (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_valid   (in_valid),
    .in_command (in_command),
    .in_ready   (in_ready),
    .status     (dp_status),
    .cmd        (dp_cmd)
  );

  // The datapath holds both lists, the head indices, the compare and the
  // output register.
  slm_dp #(
    .LIST_DEPTH (LIST_DEPTH)
  ) u_dp (
    .clk              (clk),
    .rst_n            (rst_n),
    .cmd              (dp_cmd),
    .in_value         (in_value),
    .status           (dp_status),
    .out_valid        (out_valid),
    .out_ready        (out_ready),
    .out_merged_value (out_merged_value),
    .out_from_list_b  (out_from_list_b),
    .out_last         (out_last),
    .out_overflowed   (out_overflowed)
  );

endmodule

`default_nettype wire

// ===== hw/rtl/slm_checker.sv =====
`default_nettype none

module slm_checker
  import slm_pkg::*;
(
  input wire logic              clk,
  input wire logic              rst_n,
  input wire logic              in_ready,
  input wire logic              out_valid,
  input wire logic              out_ready,
  input wire logic [DATA_W-1:0] out_merged_value,
  input wire logic              out_last,
  input wire logic              out_overflowed
);

  // A held result keeps its value until it is taken.
  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_ready |=> out_valid && $stable(out_merged_value))
    else $error("result changed while stalled");

  // While a merge is still running no new input item is taken.
  a_busy_in_merge: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_last |-> !in_ready)
    else $error("input accepted in the middle of a merge");

  // While each result is taken, a merge streams one result per cycle until its last one.
  a_no_gap: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_ready && !out_last |=> out_valid)
    else $error("gap inside a merge run");

  // The overflow flag is sticky between results.
  a_ovf_sticky: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && $past(out_valid && rst_n) && $past(out_overflowed) |-> out_overflowed)
    else $error("overflow flag cleared without reset");

endmodule

bind sorted_list_merge_unit slm_checker u_slm_checker (
  .clk              (clk),
  .rst_n            (rst_n),
  .in_ready         (in_ready),
  .out_valid        (out_valid),
  .out_ready        (out_ready),
  .out_merged_value (out_merged_value),
  .out_last         (out_last),
  .out_overflowed   (out_overflowed)
);

`default_nettype wire
